@@ rtl/mi3_pkg.sv @@
// shared types and constants for the 3x3 matrix inverse core
// no dependencies; imported by every module of the block
package mi3_pkg;

  localparam int N_ELEM     = 9;
  localparam int OUT_W      = 32;
  localparam int FRAC_SHIFT = 24;
  localparam int Q_BITS     = 33;
  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  // one lane's result toward the merge stage
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [OUT_W-1:0] q;
  } lane_out_t;

endpackage

@@ rtl/mi3_cofactor.sv @@
// cofactor and determinant pipeline, four register stages
// depends on mi3_pkg
module mi3_cofactor import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           ce,
  input  logic                           in_valid,
  input  logic signed [ELEM_WIDTH-1:0]   e [N_ELEM],
  output logic                           out_valid,
  output logic signed [2*ELEM_WIDTH:0]   adj [N_ELEM],
  output logic signed [3*ELEM_WIDTH+2:0] det
);
  localparam int W = ELEM_WIDTH;

  logic signed [2*W-1:0] pa [N_ELEM];
  logic signed [2*W-1:0] pb [N_ELEM];
  logic signed [2*W:0]   adj2 [N_ELEM];
  logic signed [2*W:0]   adj3 [N_ELEM];
  logic signed [W-1:0]   c1 [3];
  logic signed [W-1:0]   c2 [3];
  logic signed [3*W:0]   dp [3];
  logic [3:0]            vld;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[2:0], in_valid};
    end
  end
  assign out_valid = vld[3];

  // stage 1: the eighteen two-by-two products
  always_ff @(posedge clk) begin
    if (ce) begin
      pa[0] <= e[4] * e[8];  pb[0] <= e[5] * e[7];
      pa[1] <= e[2] * e[7];  pb[1] <= e[1] * e[8];
      pa[2] <= e[1] * e[5];  pb[2] <= e[2] * e[4];
      pa[3] <= e[5] * e[6];  pb[3] <= e[3] * e[8];
      pa[4] <= e[0] * e[8];  pb[4] <= e[2] * e[6];
      pa[5] <= e[2] * e[3];  pb[5] <= e[0] * e[5];
      pa[6] <= e[3] * e[7];  pb[6] <= e[4] * e[6];
      pa[7] <= e[1] * e[6];  pb[7] <= e[0] * e[7];
      pa[8] <= e[0] * e[4];  pb[8] <= e[1] * e[3];
      c1[0] <= e[0];
      c1[1] <= e[3];
      c1[2] <= e[6];
    end
  end

  // stage 2: adjugate entries, signs folded into operand order
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < N_ELEM; k++) begin
        adj2[k] <= {pa[k][2*W-1], pa[k]} - {pb[k][2*W-1], pb[k]};
      end
      c2 <= c1;
    end
  end

  // stage 3: first-column expansion products
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        dp[k] <= $signed({{(W+1){c2[k][W-1]}}, c2[k]}) * $signed({{W{adj2[k][2*W]}}, adj2[k]});
      end
      adj3 <= adj2;
    end
  end

  // stage 4: determinant sum
  always_ff @(posedge clk) begin
    if (ce) begin
      det <= {{2{dp[0][3*W]}}, dp[0]} + {{2{dp[1][3*W]}}, dp[1]}
           + {{2{dp[2][3*W]}}, dp[2]};
      adj <= adj3;
    end
  end

endmodule

@@ rtl/mi3_div_lane.sv @@
// one division lane: |adj| * 2^24 / |det|, one quotient bit per stage
// depends on mi3_pkg
module mi3_div_lane import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           ce,
  input  logic                           in_valid,
  input  logic signed [2*ELEM_WIDTH:0]   adj,
  input  logic signed [3*ELEM_WIDTH+2:0] det,
  output lane_out_t                      res
);
  localparam int W  = ELEM_WIDTH;
  localparam int AW = 2*W + 1;
  localparam int NW = AW + FRAC_SHIFT;
  localparam int DW = 3*W + 3;
  localparam int HW = NW - Q_BITS;

  logic [AW-1:0]     adj_abs;
  logic [DW-1:0]     det_abs;
  logic [NW-1:0]     num_r;
  logic [DW-1:0]     den_r;
  logic              neg_r, zero_r, vld_r;
  logic [DW-1:0]     hi_ext;

  logic [DW-1:0]     rem  [Q_BITS+1];
  logic [DW-1:0]     den  [Q_BITS+1];
  logic [Q_BITS-1:0] qa   [Q_BITS+1];
  logic [Q_BITS-1:0] lowb [Q_BITS+1];
  logic              ng   [Q_BITS+1];
  logic              ov   [Q_BITS+1];
  logic              zr   [Q_BITS+1];
  logic              vl   [Q_BITS+1];

  assign adj_abs = adj[AW-1] ? AW'(-adj) : AW'(adj);
  assign det_abs = det[DW-1] ? DW'(-det) : DW'(det);

  // entry: magnitudes and sign
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= 1'b0;
    end else if (ce) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      num_r  <= {adj_abs, {FRAC_SHIFT{1'b0}}};
      den_r  <= det_abs;
      neg_r  <= adj[AW-1] ^ det[DW-1];
      zero_r <= (det == '0);
    end
  end

  // overflow check on the bits above the quotient window
  assign hi_ext = {{(DW-HW){1'b0}}, num_r[NW-1:Q_BITS]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (ce) begin
      vl[0] <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ov[0]   <= (hi_ext >= den_r);
      rem[0]  <= (hi_ext >= den_r) ? '0 : hi_ext;
      den[0]  <= den_r;
      qa[0]   <= '0;
      lowb[0] <= num_r[Q_BITS-1:0];
      ng[0]   <= neg_r;
      zr[0]   <= zero_r;
    end
  end

  // restoring steps
  for (genvar i = 0; i < Q_BITS; i++) begin : g_step
    logic [DW:0] rem2, diff;
    logic        ge;
    assign rem2 = {rem[i], lowb[i][Q_BITS-1]};
    assign diff = rem2 - {1'b0, den[i]};
    assign ge   = !diff[DW];

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (ce) begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[i+1]  <= ge ? diff[DW-1:0] : rem2[DW-1:0];
        den[i+1]  <= den[i];
        qa[i+1]   <= {qa[i][Q_BITS-2:0], ge};
        lowb[i+1] <= {lowb[i][Q_BITS-2:0], 1'b0};
        ng[i+1]   <= ng[i];
        ov[i+1]   <= ov[i];
        zr[i+1]   <= zr[i];
      end
    end
  end

  // re-sign and saturate
  always_comb begin
    res.valid = vl[Q_BITS];
    res.zero  = zr[Q_BITS];
    if (ng[Q_BITS]) begin
      if (ov[Q_BITS] || qa[Q_BITS] > Q_BITS'(SAT_NEG)) begin
        res.q = SAT_NEG;
      end else begin
        res.q = OUT_W'(-qa[Q_BITS]);
      end
    end else begin
      if (ov[Q_BITS] || qa[Q_BITS] > Q_BITS'(SAT_POS)) begin
        res.q = SAT_POS;
      end else begin
        res.q = qa[Q_BITS][OUT_W-1:0];
      end
    end
  end

endmodule

@@ rtl/mi3_merge.sv @@
// merge of the nine lane results into one output transaction, with skid buffer
// depends on mi3_pkg
module mi3_merge import mi3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  lane_out_t              lane [N_ELEM],
  output logic                   ce,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [N_ELEM*OUT_W-1:0] m_tdata,
  output logic                   m_tuser
);
  logic [N_ELEM*OUT_W-1:0] in_data, skid_data;
  logic                    skid_user, skid_valid, pop;

  // singular matrix forces all elements to zero
  always_comb begin
    for (int k = 0; k < N_ELEM; k++) begin
      in_data[k*OUT_W +: OUT_W] = lane[0].zero ? '0 : lane[k].q;
    end
  end

  assign ce  = !skid_valid;
  assign pop = m_tvalid && m_tready;

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (lane[0].valid) begin
      if (!m_tvalid || pop) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end
    end else if (lane[0].valid) begin
      if (!m_tvalid || pop) begin
        m_tdata <= in_data;
        m_tuser <= lane[0].zero;
      end else begin
        skid_data <= in_data;
        skid_user <= lane[0].zero;
      end
    end
  end

endmodule

@@ rtl/matrix3_inverse_core.sv @@
// Inverse of a 3x3 signed Q8.8 matrix as adjugate over determinant, giving
// nine saturated Q16.16 elements and a singular flag. One matrix is accepted
// every clock cycle while the skid entry of the output buffer is empty. A
// result passes the four cofactor and determinant stages, the nine parallel
// divider lanes (one quotient bit per stage) and the output register. A two-entry
// output buffer lets the pipeline keep moving while a result waits.
// Depends on mi3_pkg, mi3_cofactor, mi3_div_lane, mi3_merge.
module matrix3_inverse_core import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // in_e0 .. in_e8, ELEM_WIDTH bits each, from the lowest bit up, zero padded
  input  logic [((N_ELEM*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // inv_e0 .. inv_e8, 32 bits each, from the lowest bit up
  output logic [N_ELEM*OUT_W-1:0] m_tdata,
  // singular
  output logic m_tuser
);
  localparam int W = ELEM_WIDTH;

  logic signed [W-1:0]     e [N_ELEM];
  logic signed [2*W:0]     adj [N_ELEM];
  logic signed [3*W+2:0]   det;
  logic                    cof_valid, ce;
  lane_out_t               lane [N_ELEM];

  // unpack input elements
  always_comb begin
    for (int k = 0; k < N_ELEM; k++) begin
      e[k] = s_tdata[k*W +: W];
    end
  end

  assign s_tready = ce;

  mi3_cofactor #(.ELEM_WIDTH(W)) u_cof (
    .clk, .rst, .ce,
    .in_valid(s_tvalid && s_tready),
    .e, .out_valid(cof_valid), .adj, .det
  );

  for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
    mi3_div_lane #(.ELEM_WIDTH(W)) u_lane (
      .clk, .rst, .ce,
      .in_valid(cof_valid), .adj(adj[k]), .det, .res(lane[k])
    );
  end

  mi3_merge u_merge (
    .clk, .rst, .lane, .ce, .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  // checks
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0) else $error("singular result not zero");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid) else $error("input stalled with empty output");
  a_lane_sync: assert property (@(posedge clk) disable iff (rst)
    lane[0].valid == lane[8].valid && lane[0].zero == lane[8].zero)
    else $error("lanes out of step");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");

endmodule
